@@ sv/rc4_pkg.sv @@
// Shared types and constants for the RC4 engine.
// No dependencies; imported by the top level.
package rc4_pkg;

  localparam int SBOX_DEPTH = 256;
  localparam int BYTE_W     = 8;
  localparam int IDX_W      = 8;
  localparam int LEN_W      = 9;
  localparam int OP_W       = 2;

  localparam logic [LEN_W-1:0] KEY_LEN_RST  = LEN_W'(16);
  localparam logic [LEN_W-1:0] KEY_LEN_FULL = LEN_W'(SBOX_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(SBOX_DEPTH - 1);

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [IDX_W-1:0]  idx_t;

  // Request opcodes; the remaining code is ignored
  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_SCHED = 2'd1,
    OP_CRYPT = 2'd2
  } opcode_t;

endpackage

@@ sv/rc4_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// Read-during-write to the same address returns the old data. No dependencies.
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read in the same edge; read returns the stored value
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/rc4_stream_cipher.sv @@
// RC4 engine top level: key store and permutation RAMs plus the sequencer.
// Depends on rc4_pkg and rc4_ram.
// Loads are written to the key store as they are accepted, one load per cycle.
// A crypt request passes through read S[i], read S[j], write S[i], write S[j] and
// output before the next is taken; a schedule keeps in_ready low through 256
// identity writes and 256 mixing swaps. A held result stalls crypt.
// Reset clears both indices and sets key length to 16; RAMs are not cleared.
module rc4_stream_cipher (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rc4_pkg::OP_W-1:0]   in_opcode,
  input  logic [rc4_pkg::IDX_W-1:0]  in_key_index,
  input  logic [rc4_pkg::BYTE_W-1:0] in_data_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rc4_pkg::BYTE_W-1:0] out_data_out,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rc4_pkg::LEN_W-1:0]  cfg_key_length
);
  import rc4_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_MIX_RD,
    ST_MIX_J,
    ST_MIX_WI,
    ST_MIX_WJ,
    ST_CR_J,
    ST_CR_WI,
    ST_CR_WJ,
    ST_CR_OUT
  } state_t;

  state_t             state_r;
  idx_t               cnt_r;
  idx_t               kpos_r;
  idx_t               mix_r;
  idx_t               i_r;
  idx_t               j_r;
  byte_t              si_r;
  byte_t              sj_r;
  byte_t              data_r;
  logic               fwd_r;
  logic [LEN_W-1:0]   key_length_r;
  logic               out_valid_r;
  byte_t              out_data_r;

  logic               in_acc;
  logic               out_load;
  opcode_t            op;
  idx_t               i_inc;
  idx_t               j_sum;
  idx_t               mix_sum;
  idx_t               t_sum;
  byte_t              ks;
  logic               len_full;
  logic [LEN_W-1:0]   len_eff;
  logic               kpos_wrap;

  logic               s_we;
  idx_t               s_waddr;
  byte_t              s_wdata;
  idx_t               s_raddr;
  byte_t              s_rdata;
  logic               k_we;
  byte_t              k_rdata;

  assign in_ready     = (state_r == ST_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;

  assign in_acc = in_valid && in_ready;
  assign op     = opcode_t'(in_opcode);

  // Crypt result goes out once the output register is free
  assign out_load = (state_r == ST_CR_OUT) && (!out_valid_r || out_ready);

  // Index arithmetic, all modulo 256
  assign i_inc   = i_r + IDX_W'(1);
  assign j_sum   = j_r + s_rdata;
  assign mix_sum = mix_r + s_rdata + k_rdata;
  assign t_sum   = si_r + sj_r;
  assign ks      = fwd_r ? si_r : s_rdata;

  // Out-of-range key length means all 256 entries
  assign len_full  = (key_length_r == '0) || (key_length_r > KEY_LEN_FULL);
  assign len_eff   = len_full ? KEY_LEN_FULL : key_length_r;
  assign kpos_wrap = (({1'b0, kpos_r} + LEN_W'(1)) == len_eff);

  // Load the key store straight from an accepted load request
  assign k_we = in_acc && (op == OP_LOAD);

  // Steer the permutation RAM ports per state
  always_comb begin
    s_we    = 1'b0;
    s_waddr = cnt_r;
    s_wdata = cnt_r;
    s_raddr = i_inc;
    unique case (state_r)
      ST_IDLE:   s_raddr = i_inc;
      ST_INIT:   s_we    = 1'b1;
      ST_MIX_RD: s_raddr = cnt_r;
      ST_MIX_J:  s_raddr = mix_sum;
      ST_MIX_WI: begin
        s_we    = 1'b1;
        s_waddr = cnt_r;
        s_wdata = s_rdata;
      end
      ST_MIX_WJ: begin
        s_we    = 1'b1;
        s_waddr = mix_r;
        s_wdata = si_r;
      end
      ST_CR_J:   s_raddr = j_sum;
      ST_CR_WI: begin
        s_we    = 1'b1;
        s_waddr = i_r;
        s_wdata = s_rdata;
      end
      ST_CR_WJ: begin
        s_we    = 1'b1;
        s_waddr = j_r;
        s_wdata = si_r;
        s_raddr = t_sum;
      end
      ST_CR_OUT: s_raddr = t_sum;
    endcase
  end

  rc4_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(SBOX_DEPTH)
  ) u_perm_ram (
    .clk  (clk),
    .we   (s_we),
    .waddr(s_waddr),
    .wdata(s_wdata),
    .raddr(s_raddr),
    .rdata(s_rdata)
  );

  rc4_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(SBOX_DEPTH)
  ) u_key_ram (
    .clk  (clk),
    .we   (k_we),
    .waddr(in_key_index),
    .wdata(in_data_byte),
    .raddr(kpos_r),
    .rdata(k_rdata)
  );

  // Sequencer: state, indices, and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      i_r          <= '0;
      j_r          <= '0;
      key_length_r <= KEY_LEN_RST;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        key_length_r <= cfg_key_length;
      end
      // Load a new result, or drop the held one once taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (op)
              OP_LOAD: ;
              OP_SCHED: begin
                cnt_r   <= '0;
                i_r     <= '0;
                j_r     <= '0;
                state_r <= ST_INIT;
              end
              OP_CRYPT: begin
                i_r     <= i_inc;
                data_r  <= in_data_byte;
                state_r <= ST_CR_J;
              end
              default: ;
            endcase
          end
        end
        // Fill the permutation with identity
        ST_INIT: begin
          cnt_r <= cnt_r + IDX_W'(1);
          if (cnt_r == IDX_LAST) begin
            mix_r   <= '0;
            kpos_r  <= '0;
            state_r <= ST_MIX_RD;
          end
        end
        ST_MIX_RD: state_r <= ST_MIX_J;
        ST_MIX_J: begin
          mix_r   <= mix_sum;
          si_r    <= s_rdata;
          state_r <= ST_MIX_WI;
        end
        ST_MIX_WI: state_r <= ST_MIX_WJ;
        // Advance the swap position and the cyclic key position
        ST_MIX_WJ: begin
          cnt_r   <= cnt_r + IDX_W'(1);
          kpos_r  <= kpos_wrap ? '0 : kpos_r + IDX_W'(1);
          state_r <= (cnt_r == IDX_LAST) ? ST_IDLE : ST_MIX_RD;
        end
        ST_CR_J: begin
          si_r    <= s_rdata;
          j_r     <= j_sum;
          state_r <= ST_CR_WI;
        end
        ST_CR_WI: begin
          sj_r    <= s_rdata;
          state_r <= ST_CR_WJ;
        end
        // Keystream read overlaps the write of S[j]; forward on a hit
        ST_CR_WJ: begin
          fwd_r   <= (t_sum == j_r);
          state_r <= ST_CR_OUT;
        end
        // Hold until the output register is free
        ST_CR_OUT: begin
          if (out_load) begin
            out_data_r <= data_r ^ ks;
            state_r    <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule
